### design/dllt_pkg.sv
// Shared types and constants for the doubly linked list table.
// Used by doubly_linked_list_table; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dllt_pkg;

   // list sizing
   localparam int ENTRIES = 1024;
   localparam int SLOTS   = ENTRIES + 2;
   localparam int SLOT_W  = $clog2(SLOTS);
   localparam int FREE_W  = $clog2(SLOTS + 1);

   // fixed field widths
   localparam int CMD_W    = 3;
   localparam int POS_W    = 11;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;

   // sentinel slots
   localparam logic [SLOT_W-1:0] HEAD_SLOT = SLOT_W'(0);
   localparam logic [SLOT_W-1:0] TAIL_SLOT = SLOT_W'(1);

   // command codes
   localparam logic [CMD_W-1:0] CMD_INS_HEAD  = CMD_W'(0);
   localparam logic [CMD_W-1:0] CMD_INS_TAIL  = CMD_W'(1);
   localparam logic [CMD_W-1:0] CMD_DELETE    = CMD_W'(2);
   localparam logic [CMD_W-1:0] CMD_INS_LEFT  = CMD_W'(3);
   localparam logic [CMD_W-1:0] CMD_INS_RIGHT = CMD_W'(4);
   localparam logic [CMD_W-1:0] CMD_WALK      = CMD_W'(5);

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK      = STATUS_W'(0);
   localparam logic [STATUS_W-1:0] STATUS_FULL    = STATUS_W'(1);
   localparam logic [STATUS_W-1:0] STATUS_INVALID = STATUS_W'(2);

   typedef struct packed {
      logic        [CMD_W-1:0]   cmd;
      logic        [POS_W-1:0]   pos;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic        [STATUS_W-1:0] status;
      logic        [POS_W-1:0]    new_pos;
      logic signed [VALUE_W-1:0]  data;
      logic                       last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_WALK,
      ST_WALK2,
      ST_LINK,
      ST_FIX,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

### design/dllt_ram.sv
// Single-port synchronous RAM with registered read data.
// Generic; no package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module dllt_ram #(
   parameter int DATA_W = 1,
   parameter int DEPTH  = 2,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] addr,
   input  wire logic [DATA_W-1:0] wr_data,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];

   // write one entry, read one entry per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end

endmodule

`default_nettype wire

### design/doubly_linked_list_table.sv
// Top level of the doubly linked list table: sequencer plus four link, value and flag RAMs.
// Depends on dllt_pkg and dllt_ram.
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_ready | dllt_pkg::req_type (cmd, pos, value)
//   rsp     | out       | rsp_valid/rsp_ready | dllt_pkg::rsp_type (status, new_pos, data, last)
//
// One request is worked at a time; req_ready is high while the sequencer is idle.
// Path per request: head/tail insert LINK, FIX, DONE; delete CHECK, FIX, DONE; left/right
// insert CHECK, LINK, FIX, DONE; walk WALK, WALK2, DONE; rejected requests reach DONE sooner.
// The result sits in an output register, so a new request is taken while it waits.
// Synchronous reset clears control state only; live slots are tracked by the fill
// count plus a deleted-flag RAM written at allocation, so no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module doubly_linked_list_table (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire dllt_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output dllt_pkg::rsp_type      rsp_data
);

   import dllt_pkg::*;

   // control and datapath registers
   state_type              state_ff, state_in;
   logic [CMD_W-1:0]       cmd_ff, cmd_in;
   logic [SLOT_W-1:0]      slot_ff, slot_in;
   logic [VALUE_W-1:0]     value_ff, value_in;
   logic [SLOT_W-1:0]      left_ff, left_in;
   logic [SLOT_W-1:0]      right_ff, right_in;
   logic [SLOT_W-1:0]      walk_ff, walk_in;
   logic [SLOT_W-1:0]      cursor_ff, cursor_in;
   logic [SLOT_W-1:0]      head_next_ff, head_next_in;
   logic [SLOT_W-1:0]      tail_prev_ff, tail_prev_in;
   logic [FREE_W-1:0]      next_free_ff, next_free_in;
   rsp_type                res_ff, res_in;
   rsp_type                rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // RAM ports
   logic                   nxt_we, prv_we, val_we, dead_we;
   logic [SLOT_W-1:0]      nxt_addr, prv_addr, val_addr, dead_addr;
   logic [SLOT_W-1:0]      nxt_wdata, prv_wdata, nxt_q, prv_q;
   logic [VALUE_W-1:0]     val_q;
   logic                   dead_wdata, dead_q;

   // decode helpers
   logic                   accept;
   logic                   full;
   logic                   range_ok;
   logic [SLOT_W-1:0]      slot_req;
   logic [SLOT_W-1:0]      node;
   logic [SLOT_W-1:0]      walk_raw;
   logic [SLOT_W-1:0]      walk_sel;
   logic                   walk_bad;
   logic                   is_delete;
   logic                   rsp_load;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign full      = (next_free_ff >= FREE_W'(SLOTS));
   assign node      = SLOT_W'(next_free_ff);
   assign is_delete = (cmd_ff == CMD_DELETE);
   assign rsp_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   // position must be in range and already allocated
   always_comb begin
      range_ok = (req_data.pos != '0)
              && (32'(req_data.pos) <= 32'(ENTRIES))
              && ((32'(req_data.pos) + 32'd1) < 32'(next_free_ff));
      slot_req = range_ok ? SLOT_W'(32'(req_data.pos) + 32'd1) : HEAD_SLOT;
   end

   // pick the walk target, wrapping past the tail back to the first element
   always_comb begin
      walk_raw = (cursor_ff == HEAD_SLOT) ? head_next_ff : nxt_q;
      walk_sel = (walk_raw == TAIL_SLOT) ? head_next_ff : walk_raw;
      walk_bad = (walk_sel == TAIL_SLOT) || (walk_sel == HEAD_SLOT);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_data.cmd)
                  CMD_INS_HEAD, CMD_INS_TAIL: state_in = full ? ST_DONE : ST_LINK;
                  CMD_DELETE, CMD_INS_LEFT, CMD_INS_RIGHT:
                     state_in = range_ok ? ST_CHECK : ST_DONE;
                  CMD_WALK: state_in = ST_WALK;
                  default:  state_in = ST_DONE;
               endcase
            end
         end
         ST_CHECK: begin
            if (dead_q) begin
               state_in = ST_DONE;
            end else if (is_delete) begin
               state_in = ST_FIX;
            end else begin
               state_in = full ? ST_DONE : ST_LINK;
            end
         end
         ST_WALK:  state_in = walk_bad ? ST_DONE : ST_WALK2;
         ST_WALK2: state_in = ST_DONE;
         ST_LINK:  state_in = ST_FIX;
         ST_FIX:   state_in = ST_DONE;
         ST_DONE:  state_in = rsp_load ? ST_IDLE : ST_DONE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // RAM addressing and writes
   always_comb begin
      nxt_we     = 1'b0;
      prv_we     = 1'b0;
      val_we     = 1'b0;
      dead_we    = 1'b0;
      nxt_addr   = slot_ff;
      prv_addr   = slot_ff;
      val_addr   = walk_ff;
      dead_addr  = slot_ff;
      nxt_wdata  = right_ff;
      prv_wdata  = left_ff;
      dead_wdata = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            nxt_addr  = (req_data.cmd == CMD_WALK) ? cursor_ff : slot_req;
            prv_addr  = slot_req;
            dead_addr = slot_req;
         end
         ST_WALK: begin
            nxt_addr = walk_sel;
            val_addr = walk_sel;
         end
         ST_LINK: begin
            // fill the new node
            nxt_we     = 1'b1;
            prv_we     = 1'b1;
            val_we     = 1'b1;
            dead_we    = 1'b1;
            nxt_addr   = node;
            prv_addr   = node;
            val_addr   = node;
            dead_addr  = node;
            nxt_wdata  = right_ff;
            prv_wdata  = left_ff;
            dead_wdata = 1'b0;
         end
         ST_FIX: begin
            // splice neighbors; sentinel links live in registers
            nxt_we     = (left_ff != HEAD_SLOT);
            prv_we     = (right_ff != TAIL_SLOT);
            nxt_addr   = left_ff;
            prv_addr   = right_ff;
            nxt_wdata  = is_delete ? right_ff : node;
            prv_wdata  = is_delete ? left_ff : node;
            dead_we    = is_delete;
            dead_addr  = slot_ff;
            dead_wdata = 1'b1;
         end
         default: begin
            nxt_we = 1'b0;
         end
      endcase
   end

   // datapath next values
   always_comb begin
      cmd_in       = cmd_ff;
      slot_in      = slot_ff;
      value_in     = value_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      walk_in      = walk_ff;
      cursor_in    = cursor_ff;
      head_next_in = head_next_ff;
      tail_prev_in = tail_prev_ff;
      next_free_in = next_free_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in   = req_data.cmd;
               slot_in  = slot_req;
               value_in = req_data.value;
               res_in   = '0;
               case (req_data.cmd)
                  CMD_INS_HEAD: begin
                     left_in  = HEAD_SLOT;
                     right_in = head_next_ff;
                     if (full) res_in.status = STATUS_FULL;
                  end
                  CMD_INS_TAIL: begin
                     left_in  = tail_prev_ff;
                     right_in = TAIL_SLOT;
                     if (full) res_in.status = STATUS_FULL;
                  end
                  CMD_DELETE, CMD_INS_LEFT, CMD_INS_RIGHT: begin
                     if (!range_ok) res_in.status = STATUS_INVALID;
                  end
                  default: begin
                     res_in.status = STATUS_OK;
                  end
               endcase
            end
         end
         ST_CHECK: begin
            if (dead_q) begin
               res_in.status = STATUS_INVALID;
            end else begin
               case (cmd_ff)
                  CMD_INS_RIGHT: begin
                     left_in  = slot_ff;
                     right_in = nxt_q;
                  end
                  CMD_INS_LEFT: begin
                     left_in  = prv_q;
                     right_in = slot_ff;
                  end
                  default: begin
                     left_in  = prv_q;
                     right_in = nxt_q;
                  end
               endcase
               if (!is_delete && full) res_in.status = STATUS_FULL;
            end
         end
         ST_WALK: begin
            if (walk_bad) begin
               res_in.status = STATUS_INVALID;
               cursor_in     = HEAD_SLOT;
            end else begin
               walk_in = walk_sel;
            end
         end
         ST_WALK2: begin
            res_in.data = val_q;
            res_in.last = (nxt_q == TAIL_SLOT);
            cursor_in   = walk_ff;
         end
         ST_FIX: begin
            cursor_in = HEAD_SLOT;
            if (is_delete) begin
               if (left_ff == HEAD_SLOT) head_next_in = right_ff;
               if (right_ff == TAIL_SLOT) tail_prev_in = left_ff;
            end else begin
               if (left_ff == HEAD_SLOT) head_next_in = node;
               if (right_ff == TAIL_SLOT) tail_prev_in = node;
               next_free_in   = next_free_ff + FREE_W'(1);
               res_in.new_pos = POS_W'(node - SLOT_W'(1));
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            res_in = res_ff;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cursor_ff    <= HEAD_SLOT;
         head_next_ff <= TAIL_SLOT;
         tail_prev_ff <= HEAD_SLOT;
         next_free_ff <= FREE_W'(2);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cursor_ff    <= cursor_in;
         head_next_ff <= head_next_in;
         tail_prev_ff <= tail_prev_in;
         next_free_ff <= next_free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      slot_ff  <= slot_in;
      value_ff <= value_in;
      left_ff  <= left_in;
      right_ff <= right_in;
      walk_ff  <= walk_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
   end

   // successor links
   dllt_ram #(.DATA_W(SLOT_W), .DEPTH(SLOTS)) u_next_ram (
      .clock   (clock),
      .wr_en   (nxt_we),
      .addr    (nxt_addr),
      .wr_data (nxt_wdata),
      .rd_data (nxt_q)
   );

   // predecessor links
   dllt_ram #(.DATA_W(SLOT_W), .DEPTH(SLOTS)) u_prev_ram (
      .clock   (clock),
      .wr_en   (prv_we),
      .addr    (prv_addr),
      .wr_data (prv_wdata),
      .rd_data (prv_q)
   );

   // node values
   dllt_ram #(.DATA_W(VALUE_W), .DEPTH(SLOTS)) u_value_ram (
      .clock   (clock),
      .wr_en   (val_we),
      .addr    (val_addr),
      .wr_data (value_ff),
      .rd_data (val_q)
   );

   // deleted flags, written when a slot is allocated or deleted
   dllt_ram #(.DATA_W(1), .DEPTH(SLOTS)) u_dead_ram (
      .clock   (clock),
      .wr_en   (dead_we),
      .addr    (dead_addr),
      .wr_data (dead_wdata),
      .rd_data (dead_q)
   );

endmodule

`default_nettype wire
